@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthands for clocked concurrent assertions with async reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/kcalc_pkg.sv @@
// ---------------------------------------------------------------------------
// kcalc_pkg
// widths, key codes and controller/datapath interface types of the calculator
// ---------------------------------------------------------------------------
package kcalc_pkg;

	// operand word width and width of the iteration step counter
	localparam int WORD_WIDTH = 32;
	localparam int CNT_W      = $clog2(WORD_WIDTH);

	// port widths
	localparam int KEY_W    = 7;
	localparam int ANSWER_W = 32;

	// key codes
	localparam logic [KEY_W-1:0] KEY_ADD  = 7'h2B;
	localparam logic [KEY_W-1:0] KEY_SUB  = 7'h2D;
	localparam logic [KEY_W-1:0] KEY_MUL  = 7'h2A;
	localparam logic [KEY_W-1:0] KEY_DIV  = 7'h2F;
	localparam logic [KEY_W-1:0] KEY_EQU  = 7'h3D;
	localparam logic [KEY_W-1:0] KEY_CLR  = 7'h43;
	localparam logic [KEY_W-1:0] KEY_ZERO = 7'h30;
	localparam logic [KEY_W-1:0] KEY_NINE = 7'h39;

	// what the output register is loaded with
	typedef enum logic [1:0] {
		OUT_SILENT,
		OUT_ECHO,
		OUT_ANSWER,
		OUT_CLEAR
	} out_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      acc_first;
		logic      acc_second;
		logic      set_op;
		logic      clear_all;
		logic      start_calc;
		logic      calc_step;
		logic      out_load;
		out_kind_t out_kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic key_digit;
		logic key_equ;
		logic key_clr;
	} dp_status_t;

endpackage

@@ design/kcalc_ctrl.sv @@
// ---------------------------------------------------------------------------
// kcalc_ctrl
// controller: entry phase, calculation sequencing and handshakes
// ---------------------------------------------------------------------------
module kcalc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  kcalc_pkg::dp_status_t status,
	output kcalc_pkg::dp_cmd_t    cmd
);
	import kcalc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_ANSWER
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_WAIT
	} phase_t;

	state_t           state_q;
	phase_t           phase_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_take;

	// handshakes: take a key when idle and the output slot is free or freeing
	assign out_take  = out_valid_q && !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.out_load = 1'b1;
					case (phase_q)
						PH_FIRST: begin
							cmd.acc_first = status.key_digit;
							cmd.set_op    = !status.key_digit;
							cmd.out_kind  = OUT_ECHO;
						end
						PH_SECOND: begin
							if (status.key_digit) begin
								cmd.acc_second = 1'b1;
								cmd.out_kind   = OUT_ECHO;
							end else if (status.key_equ) begin
								cmd.start_calc = 1'b1;
								cmd.out_load   = 1'b0;
							end else begin
								cmd.out_kind = OUT_SILENT;
							end
						end
						default: begin
							if (status.key_clr) begin
								cmd.clear_all = 1'b1;
								cmd.out_kind  = OUT_CLEAR;
							end else begin
								cmd.out_kind = OUT_SILENT;
							end
						end
					endcase
				end
			end
			ST_CALC: begin
				cmd.calc_step = 1'b1;
			end
			ST_ANSWER: begin
				cmd.out_load = 1'b1;
				cmd.out_kind = OUT_ANSWER;
			end
			default: begin
			end
		endcase
	end

	// state, phase, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FIRST;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (phase_q)
							PH_FIRST: begin
								if (!status.key_digit) begin
									phase_q <= PH_SECOND;
								end
							end
							PH_SECOND: begin
								if (status.key_equ) begin
									phase_q <= PH_WAIT;
									state_q <= ST_CALC;
									count_q <= CNT_W'(WORD_WIDTH - 1);
								end
							end
							default: begin
								if (status.key_clr) begin
									phase_q <= PH_FIRST;
								end
							end
						endcase
					end
				end
				ST_CALC: begin
					if (count_q == '0) begin
						state_q <= ST_ANSWER;
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
				ST_ANSWER: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/kcalc_dp.sv @@
// ---------------------------------------------------------------------------
// kcalc_dp
// datapath: operands, operator, bit-serial multiply/divide, output register
// ---------------------------------------------------------------------------
module kcalc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [kcalc_pkg::KEY_W-1:0]     key,
	input  kcalc_pkg::dp_cmd_t              cmd,
	output kcalc_pkg::dp_status_t           status,
	output logic                            echo_valid,
	output logic [kcalc_pkg::KEY_W-1:0]     echo_char,
	output logic                            answer_valid,
	output logic [kcalc_pkg::ANSWER_W-1:0]  answer,
	output logic                            cleared
);
	import kcalc_pkg::*;

	logic [WORD_WIDTH-1:0] first_q;
	logic [WORD_WIDTH-1:0] second_q;
	logic [KEY_W-1:0]      op_q;
	logic [WORD_WIDTH-1:0] mcand_q;
	logic [WORD_WIDTH-1:0] mplier_q;
	logic [WORD_WIDTH-1:0] prod_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [WORD_WIDTH-1:0] quo_q;
	logic [WORD_WIDTH:0]   div_shift;
	logic [WORD_WIDTH:0]   div_trial;
	logic                  div_fits;
	logic [WORD_WIDTH-1:0] result;

	logic                  echo_valid_q;
	logic [KEY_W-1:0]      echo_char_q;
	logic                  answer_valid_q;
	logic [ANSWER_W-1:0]   answer_q;
	logic                  cleared_q;

	// n * 10 + d, wrapping to the word
	function automatic logic [WORD_WIDTH-1:0] acc_digit(input logic [WORD_WIDTH-1:0] n,
			input logic [3:0] d);
		return (n << 3) + (n << 1) + WORD_WIDTH'(d);
	endfunction

	// key classification
	assign status.key_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
	assign status.key_equ   = (key == KEY_EQU);
	assign status.key_clr   = (key == KEY_CLR);

	// restoring divide step: shift in next dividend bit, try the subtract
	assign div_shift = {rem_q, quo_q[WORD_WIDTH-1]};
	assign div_trial = div_shift - {1'b0, second_q};
	assign div_fits  = !div_trial[WORD_WIDTH];

	// answer select
	always_comb begin
		case (op_q)
			KEY_ADD: result = first_q + second_q;
			KEY_SUB: result = first_q - second_q;
			KEY_MUL: result = prod_q;
			KEY_DIV: result = (second_q == '0) ? '0 : quo_q;
			default: result = '0;
		endcase
	end

	// operands and operator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			op_q     <= '0;
		end else if (cmd.clear_all) begin
			first_q  <= '0;
			second_q <= '0;
			op_q     <= '0;
		end else begin
			if (cmd.acc_first) begin
				first_q <= acc_digit(first_q, key[3:0]);
			end
			if (cmd.acc_second) begin
				second_q <= acc_digit(second_q, key[3:0]);
			end
			if (cmd.set_op) begin
				op_q <= key;
			end
		end
	end

	// shift-add multiplier and restoring divider, one bit per step
	always_ff @(posedge clk) begin
		if (cmd.start_calc) begin
			mcand_q  <= first_q;
			mplier_q <= second_q;
			prod_q   <= '0;
			rem_q    <= '0;
			quo_q    <= first_q;
		end else if (cmd.calc_step) begin
			prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			rem_q    <= div_fits ? div_trial[WORD_WIDTH-1:0] : div_shift[WORD_WIDTH-1:0];
			quo_q    <= {quo_q[WORD_WIDTH-2:0], div_fits};
		end
	end

	// output register, loaded once per transaction
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			echo_valid_q   <= (cmd.out_kind == OUT_ECHO);
			echo_char_q    <= (cmd.out_kind == OUT_ECHO) ? key : '0;
			answer_valid_q <= (cmd.out_kind == OUT_ANSWER);
			answer_q       <= (cmd.out_kind == OUT_ANSWER) ? ANSWER_W'(result) : '0;
			cleared_q      <= (cmd.out_kind == OUT_CLEAR);
		end
	end

	assign echo_valid   = echo_valid_q;
	assign echo_char    = echo_char_q;
	assign answer_valid = answer_valid_q;
	assign answer       = answer_q;
	assign cleared      = cleared_q;

endmodule

@@ design/keypad_four_function_calculator_top.sv @@
// ---------------------------------------------------------------------------
// keypad_four_function_calculator_top
// four-function calculator fed by key codes, one result per key
// ---------------------------------------------------------------------------
// Every accepted key gives exactly one output transaction. Digits, operator
// keys and ignored keys are answered in the cycle after acceptance. The '='
// key starts a bit-serial calculation: the shift-add multiplier and the
// restoring divider both retire one bit per cycle; when the last step is done
// the answer state loads the result into the output register, whatever the
// operator. No key is taken during that calculation, nor while a finished
// result is held by out_stall.
module keypad_four_function_calculator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [kcalc_pkg::KEY_W-1:0]    key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           echo_valid,
	output logic [kcalc_pkg::KEY_W-1:0]    echo_char,
	output logic                           answer_valid,
	output logic [kcalc_pkg::ANSWER_W-1:0] answer,
	output logic                           cleared
);
	import kcalc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// controller
	kcalc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	kcalc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (key),
		.cmd          (cmd),
		.status       (status),
		.echo_valid   (echo_valid),
		.echo_char    (echo_char),
		.answer_valid (answer_valid),
		.answer       (answer),
		.cleared      (cleared)
	);

endmodule

@@ design/kcalc_checker.sv @@
// ---------------------------------------------------------------------------
// kcalc_checker
// port-level checks on the calculator's output transactions
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kcalc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           echo_valid,
	input logic [kcalc_pkg::KEY_W-1:0]    echo_char,
	input logic                           answer_valid,
	input logic [kcalc_pkg::ANSWER_W-1:0] answer,
	input logic                           cleared
);
	import kcalc_pkg::*;

	// a stalled transaction holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(answer) && $stable(echo_char), "stalled output changed")

	// a key is echoed, answered or clears, never more than one
	`ASSERT_IMPLY(a_one_kind, clk, arst_n, out_valid, $onehot0({echo_valid, answer_valid, cleared}), "more than one result kind")

	// no echo means a zero character
	`ASSERT_IMPLY(a_echo_zero, clk, arst_n, out_valid && !echo_valid, echo_char == '0, "echo_char set without echo")

	// no answer means a zero answer
	`ASSERT_IMPLY(a_answer_zero, clk, arst_n, out_valid && !answer_valid, answer == '0, "answer set without answer_valid")

endmodule

bind keypad_four_function_calculator_top kcalc_checker u_kcalc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.echo_valid   (echo_valid),
	.echo_char    (echo_char),
	.answer_valid (answer_valid),
	.answer       (answer),
	.cleared      (cleared)
);

@@ bench/keypad_four_function_calculator_top_tb.sv @@
// ---------------------------------------------------------------------------
// keypad_four_function_calculator_top_tb
// drives key codes into the calculator and checks every output transaction
// ---------------------------------------------------------------------------
// A scoreboard keeps its own copy of the phase, both operands and the
// operator, and queues the display it expects for each accepted key. A short
// directed run covers the corner cases: key codes 0 and 127 as operators,
// the unknown operator, division by zero, wrap on subtract, and
// ignored keys. Random whole calculations follow, mixed with noise keys,
// under three idle patterns on the sender and the receiver.
`timescale 1ns / 100ps

import kcalc_pkg::*;

typedef enum logic [1:0] {
	ENTER_FIRST,
	ENTER_SECOND,
	AWAIT_CLEAR
} calc_phase_t;

typedef struct {
	logic                echo_valid;
	logic [KEY_W-1:0]    echo_char;
	logic                answer_valid;
	logic [ANSWER_W-1:0] answer;
	logic                cleared;
} display_t;

class calc_scoreboard;
	calc_phase_t           phase;
	logic [WORD_WIDTH-1:0] first_operand;
	logic [WORD_WIDTH-1:0] second_operand;
	logic [KEY_W-1:0]      operator_key;
	display_t              pending_displays[$];
	int                    mismatches;

	function new();
		clear_state();
		mismatches = 0;
	endfunction

	function void clear_state();
		phase          = ENTER_FIRST;
		first_operand  = '0;
		second_operand = '0;
		operator_key   = '0;
	endfunction

	function bit is_digit(logic [KEY_W-1:0] k);
		return k >= KEY_ZERO && k <= KEY_NINE;
	endfunction

	// decimal shift-in, wraps at word width
	function logic [WORD_WIDTH-1:0] shift_in_digit(logic [WORD_WIDTH-1:0] acc,
		logic [KEY_W-1:0] k);
		logic [WORD_WIDTH-1:0] digit;
		digit = WORD_WIDTH'(k - KEY_ZERO);
		return acc * WORD_WIDTH'(10) + digit;
	endfunction

	// four-function result, zero for division by zero or unknown operator
	function logic [WORD_WIDTH-1:0] evaluate();
		case (operator_key)
			KEY_ADD: return first_operand + second_operand;
			KEY_SUB: return first_operand - second_operand;
			KEY_MUL: return first_operand * second_operand;
			KEY_DIV: begin
				if (second_operand == '0)
					return '0;
				return first_operand / second_operand;
			end
			default: return '0;
		endcase
	endfunction

	// advance the calculator by one key and queue the display it causes
	function void note_key(logic [KEY_W-1:0] k);
		display_t d;
		d = '{1'b0, '0, 1'b0, '0, 1'b0};
		case (phase)
			ENTER_FIRST: begin
				if (is_digit(k)) begin
					first_operand = shift_in_digit(first_operand, k);
				end else begin
					operator_key = k;
					phase        = ENTER_SECOND;
				end
				d.echo_valid = 1'b1;
				d.echo_char  = k;
			end
			ENTER_SECOND: begin
				if (is_digit(k)) begin
					second_operand = shift_in_digit(second_operand, k);
					d.echo_valid   = 1'b1;
					d.echo_char    = k;
				end else if (k == KEY_EQU) begin
					d.answer       = ANSWER_W'(evaluate());
					d.answer_valid = 1'b1;
					phase          = AWAIT_CLEAR;
				end
			end
			default: begin
				if (k == KEY_CLR) begin
					clear_state();
					d.cleared = 1'b1;
				end
			end
		endcase
		pending_displays.push_back(d);
	endfunction

	// compare one output transaction with the oldest expected display
	function void check_display(logic ev, logic [KEY_W-1:0] ec, logic av,
		logic [ANSWER_W-1:0] ans, logic clr);
		display_t d;
		if (pending_displays.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected transaction: echo %0b/%h answer %0b/%h cleared %0b",
					ev, ec, av, ans, clr);
			return;
		end
		d = pending_displays.pop_front();
		if (ev !== d.echo_valid || ec !== d.echo_char || av !== d.answer_valid ||
			ans !== d.answer || clr !== d.cleared) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected echo %0b/%h answer %0b/%h cleared %0b",
					d.echo_valid, d.echo_char, d.answer_valid, d.answer, d.cleared);
				$display("          actual   echo %0b/%h answer %0b/%h cleared %0b",
					ev, ec, av, ans, clr);
			end
		end
	endfunction

	function int outstanding();
		return pending_displays.size();
	endfunction
endclass

module keypad_four_function_calculator_top_tb;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [KEY_W-1:0]    key          = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                echo_valid;
	logic [KEY_W-1:0]    echo_char;
	logic                answer_valid;
	logic [ANSWER_W-1:0] answer;
	logic                cleared;

	calc_scoreboard sb = new();
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             keys_sent     = 0;

	keypad_four_function_calculator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key          (key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.echo_valid   (echo_valid),
		.echo_char    (echo_char),
		.answer_valid (answer_valid),
		.answer       (answer),
		.cleared      (cleared)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("[keypad_four_function_calculator_top] ERROR");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	// output transaction check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_display(echo_valid, echo_char, answer_valid, answer, cleared);
	end

	// present one key, hold it until the calculator accepts it
	task automatic press_key(input logic [KEY_W-1:0] k);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		key      = k;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_key(k);
		keys_sent++;
	endtask

	task automatic press_digit();
		press_key(KEY_ZERO + KEY_W'($urandom_range(9)));
	endtask

	task automatic press_noise();
		press_key(KEY_W'($urandom_range(127)));
	endtask

	// operand length: mostly short, some long enough to wrap, some empty
	function automatic int digit_count();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 70)
			return $urandom_range(1, 3);
		return $urandom_range(4, 12);
	endfunction

	// one complete calculation with random operands and some noise
	task automatic run_calculation();
		int n;
		// bring the calculator back to operand entry first
		if (sb.phase == ENTER_SECOND)
			press_key(KEY_EQU);
		if (sb.phase == AWAIT_CLEAR)
			press_key(KEY_CLR);
		n = digit_count();
		repeat (n) press_digit();
		if ($urandom_range(99) < 15) begin
			press_noise();
		end else begin
			case ($urandom_range(3))
				0: press_key(KEY_ADD);
				1: press_key(KEY_SUB);
				2: press_key(KEY_MUL);
				default: press_key(KEY_DIV);
			endcase
		end
		n = digit_count();
		repeat (n) begin
			if ($urandom_range(99) < 10)
				press_noise();
			press_digit();
		end
		press_key(KEY_EQU);
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 3)) press_noise();
		press_key(KEY_CLR);
	endtask

	task automatic run_random(input int count);
		int target;
		target = keys_sent + count;
		while (keys_sent < target) begin
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(1, 8)) press_noise();
			else
				run_calculation();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: multiply, subtract wrap, divide by zero
		press_key(KEY_ZERO + KEY_W'(7));
		press_key(KEY_MUL);
		press_key(KEY_ZERO + KEY_W'(6));
		press_key(KEY_EQU);
		press_key(KEY_CLR);
		press_key(KEY_ZERO);
		press_key(KEY_SUB);
		press_key(KEY_ZERO + KEY_W'(1));
		press_key(KEY_EQU);
		press_key(KEY_ZERO + KEY_W'(5));
		press_key(KEY_CLR);
		press_key(KEY_ZERO + KEY_W'(8));
		press_key(KEY_DIV);
		press_key(KEY_ZERO);
		press_key(KEY_EQU);
		press_key(KEY_CLR);
		// key codes at both ends taken as unknown operators
		press_key(7'h7F);
		press_key(KEY_ZERO + KEY_W'(3));
		press_key(KEY_ADD);
		press_key(KEY_EQU);
		press_key(KEY_CLR);
		press_key(7'h00);
		press_key(KEY_EQU);
		press_key(KEY_CLR);

		// random: sender idles lightly, then heavily, then no idling
		send_idle_pct = 19;
		recv_idle_pct = 50;
		run_random(550);
		send_idle_pct = 50;
		recv_idle_pct = 19;
		run_random(550);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(550);

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[keypad_four_function_calculator_top] OK");
		else
			$display("[keypad_four_function_calculator_top] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/kcalc_pkg.sv
design/kcalc_ctrl.sv
design/kcalc_dp.sv
design/keypad_four_function_calculator_top.sv
design/kcalc_checker.sv
bench/keypad_four_function_calculator_top_tb.sv
